[rtl/cekd_pkg.sv]
package cekd_pkg;

	localparam int KEY_W   = 8;
	localparam int DIGIT_W = 4;
	localparam int COUNT_W = 2;
	localparam int STORE_N = 3;

	typedef logic [1:0] method_t;

	localparam method_t METHOD_PASS  = 2'd0;
	localparam method_t METHOD_HEX   = 2'd1;
	localparam method_t METHOD_QUWEI = 2'd2;

	localparam logic [KEY_W-1:0] KEY_BS   = 8'h08;
	localparam logic [KEY_W-1:0] KEY_DEL  = 8'h7f;
	localparam logic [KEY_W-1:0] KEY_CR   = 8'h0d;
	localparam logic [KEY_W-1:0] KEY_NAK  = 8'h15;
	localparam logic [KEY_W-1:0] HIGH_BIT = 8'h80;
	localparam logic [KEY_W-1:0] QW_BASE  = 8'ha0;
	localparam logic [KEY_W-1:0] QW_MUL   = 8'd10;

	localparam logic [COUNT_W-1:0] COUNT_FULL = 2'd3;

	typedef logic [STORE_N-1:0][DIGIT_W-1:0] digit_arr_t;

	typedef struct packed {
		logic               emit;
		logic               two;
		logic [KEY_W-1:0]   byte0;
		logic [KEY_W-1:0]   byte1;
		logic               store_we;
		logic [DIGIT_W-1:0] digit;
		logic [COUNT_W-1:0] count_next;
	} dec_t;

endpackage

[rtl/cekd_decode.sv]
module cekd_decode (
	input  cekd_pkg::method_t              method,
	input  logic [cekd_pkg::KEY_W-1:0]     key,
	input  logic [cekd_pkg::COUNT_W-1:0]   count,
	input  cekd_pkg::digit_arr_t           store,
	output cekd_pkg::dec_t                 dec
);
	import cekd_pkg::*;

	logic               is_digit;
	logic [DIGIT_W-1:0] d;
	logic [KEY_W-1:0]   hb0;
	logic [KEY_W-1:0]   hb1;
	logic [KEY_W-1:0]   qb0;
	logic [KEY_W-1:0]   qb1;
	logic               entry_mode;

	assign entry_mode = (method == METHOD_HEX) || (method == METHOD_QUWEI);

	always_comb begin
		is_digit = 1'b0;
		d        = '0;
		if (key >= "0" && key <= "9") begin
			is_digit = 1'b1;
			d        = DIGIT_W'(key - 8'("0"));
		end else if (method == METHOD_HEX && key >= "a" && key <= "f") begin
			is_digit = 1'b1;
			d        = DIGIT_W'(key - 8'("a") + 8'd10);
		end else if (method == METHOD_HEX && key >= "A" && key <= "F") begin
			is_digit = 1'b1;
			d        = DIGIT_W'(key - 8'("A") + 8'd10);
		end
	end

	// hex code, high bit forced when first byte is below 0x80
	always_comb begin
		hb0 = {store[0], store[1]};
		hb1 = {store[2], d};
		if (!hb0[KEY_W-1]) begin
			hb0 = hb0 | HIGH_BIT;
			hb1 = hb1 | HIGH_BIT;
		end
	end

	assign qb0 = 8'(8'(store[0]) * QW_MUL + 8'(store[1]) + QW_BASE);
	assign qb1 = 8'(8'(store[2]) * QW_MUL + 8'(d) + QW_BASE);

	always_comb begin
		dec            = '0;
		dec.emit       = 1'b1;
		dec.byte0      = key;
		dec.digit      = d;
		dec.count_next = count;
		if (entry_mode) begin
			if (is_digit) begin
				if (count == COUNT_FULL) begin
					dec.two        = 1'b1;
					dec.byte0      = (method == METHOD_HEX) ? hb0 : qb0;
					dec.byte1      = (method == METHOD_HEX) ? hb1 : qb1;
					dec.count_next = '0;
				end else begin
					dec.emit       = 1'b0;
					dec.store_we   = 1'b1;
					dec.count_next = count + 2'd1;
				end
			end else if (key == KEY_BS || key == KEY_DEL) begin
				if (count != '0) begin
					dec.emit       = 1'b0;
					dec.count_next = count - 2'd1;
				end
			end else if (key == KEY_CR || key == KEY_NAK) begin
				if (count != '0) begin
					dec.emit       = 1'b0;
					dec.count_next = '0;
				end
			end
		end
	end

endmodule

[rtl/code_entry_key_decoder_unit.sv]
// code entry key decoder
// keystroke bytes enter on the s_ side, one item per tdata byte. in pass-through
// mode every key goes out unchanged. in hex or qu-wei mode digit keys are held
// until the fourth one, which sends a two-byte code (first byte with tlast low,
// second with tlast high). backspace/DEL drop one held digit, CR/ctrl-U drop all;
// with nothing held these keys, like any other key, go out with tlast high.
// cfg_we writes the method (0 pass, 1 hex, 2 qu-wei) and clears held digits;
// write only while the block is idle.
// an accepted key is captured in the input register, decoded from it there, and
// its first output item is then registered in the output register.
// throughput: one key per cycle while m_tready stays high and keys give at
// most one output item; a code's two bytes share the single output port in turn.
// a stalled receiver fills the output register (and for a code its second-byte
// slot), then the input register, then s_tready drops; nothing is lost.
// reset clears the method to pass-through, the held digit count and all valids.
module code_entry_key_decoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  cekd_pkg::method_t            cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cekd_pkg::KEY_W-1:0]   s_tdata,   // key
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cekd_pkg::KEY_W-1:0]   m_tdata,   // out_byte
	output logic                         m_tlast    // last
);
	import cekd_pkg::*;

	method_t            method_q;
	logic [COUNT_W-1:0] count_q;
	digit_arr_t         store_q;

	logic               valid_s1;
	logic [KEY_W-1:0]   key_s1;

	logic               out_valid_q;
	logic [KEY_W-1:0]   out_byte_q;
	logic               out_last_q;
	logic               pend_valid_q;
	logic [KEY_W-1:0]   pend_byte_q;

	dec_t               dec;
	logic               out_free;
	logic               advance;
	logic               pop;

	cekd_decode u_decode (
		.method (method_q),
		.key    (key_s1),
		.count  (count_q),
		.store  (store_q),
		.dec    (dec)
	);

	assign pop      = out_valid_q && m_tready;
	assign out_free = !out_valid_q || (m_tready && !pend_valid_q);
	assign advance  = valid_s1 && (out_free || !dec.emit);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_PASS;
			count_q  <= '0;
		end else if (cfg_we) begin
			method_q <= cfg_wdata;
			count_q  <= '0;
		end else if (advance) begin
			count_q <= dec.count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.store_we) begin
			store_q[count_q] <= dec.digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (advance && dec.emit) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= dec.two;
		end else if (pop) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit) begin
			out_byte_q  <= dec.byte0;
			out_last_q  <= !dec.two;
			pend_byte_q <= dec.byte1;
		end else if (pop && pend_valid_q) begin
			out_byte_q <= pend_byte_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule
